/* hdl/atatf_pkg.sv */
// atatf_pkg: widths, codes, command bytes and shared types of the taskfile issue block
// no dependencies; compiled first
package atatf_pkg;

  localparam int KIND_W       = 3;
  localparam int LBA_W        = 48;
  localparam int COUNT_W      = 16;
  localparam int TARGET_W     = 2;
  localparam int OFFSET_W     = 3;
  localparam int VALUE_W      = 16;
  localparam int STATUS_W     = 2;
  localparam int STEP_W       = 4;
  localparam int SECTOR_SHIFT = 9;
  localparam int BYTES_W      = COUNT_W + SECTOR_SHIFT;
  localparam int LBA28_BITS   = 28;

  // longest single dma transfer in bytes
  localparam int unsigned MAX_DMA_BYTES = 65536;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_PIO28_RD = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PIO28_WR = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PIO48_RD = 3'd2;
  localparam logic [KIND_W-1:0] KIND_PIO48_WR = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DMA_RD   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_DMA_WR   = 3'd5;

  // write targets
  localparam logic [TARGET_W-1:0] TGT_TASKFILE = 2'd0;
  localparam logic [TARGET_W-1:0] TGT_BMCMD    = 2'd1;
  localparam logic [TARGET_W-1:0] TGT_PRD      = 2'd2;
  localparam logic [TARGET_W-1:0] TGT_NONE     = 2'd3;

  // taskfile register offsets
  localparam logic [OFFSET_W-1:0] OFF_NONE    = 3'd0;
  localparam logic [OFFSET_W-1:0] OFF_COUNT   = 3'd2;
  localparam logic [OFFSET_W-1:0] OFF_LBA_LO  = 3'd3;
  localparam logic [OFFSET_W-1:0] OFF_LBA_MID = 3'd4;
  localparam logic [OFFSET_W-1:0] OFF_LBA_HI  = 3'd5;
  localparam logic [OFFSET_W-1:0] OFF_DEVICE  = 3'd6;
  localparam logic [OFFSET_W-1:0] OFF_COMMAND = 3'd7;

  // completion status
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_DEV   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG = 2'd2;

  // configuration register indexes
  localparam logic CFG_DEVICE_PRESENT = 1'b0;
  localparam logic CFG_DMA_AVAILABLE  = 1'b1;

  // command and control bytes
  localparam logic [7:0] CMD_READ_SECTORS      = 8'h20;
  localparam logic [7:0] CMD_WRITE_SECTORS     = 8'h30;
  localparam logic [7:0] CMD_READ_SECTORS_EXT  = 8'h24;
  localparam logic [7:0] CMD_WRITE_SECTORS_EXT = 8'h34;
  localparam logic [7:0] CMD_READ_DMA          = 8'hC8;
  localparam logic [7:0] CMD_WRITE_DMA         = 8'hCA;
  localparam logic [7:0] CMD_READ_DMA_EXT      = 8'h25;
  localparam logic [7:0] CMD_WRITE_DMA_EXT     = 8'h35;
  localparam logic [7:0] DEV_LBA28             = 8'hE0;
  localparam logic [7:0] DEV_LBA48             = 8'h40;
  localparam logic [7:0] BM_STOP               = 8'h00;
  localparam logic [7:0] BM_DIR_READ           = 8'h08;
  localparam logic [7:0] BM_START              = 8'h01;

  localparam logic [COUNT_W-1:0] DMA28_MAX_COUNT = 16'd256;

  // index of the final write for each request shape
  localparam logic [STEP_W-1:0] LAST_NONE  = 4'd0;
  localparam logic [STEP_W-1:0] LAST_PIO28 = 4'd5;
  localparam logic [STEP_W-1:0] LAST_PIO48 = 4'd9;
  localparam logic [STEP_W-1:0] LAST_DMA28 = 4'd9;
  localparam logic [STEP_W-1:0] LAST_DMA48 = 4'd13;

  // first taskfile write in a dma sequence
  localparam logic [STEP_W-1:0] DMA_TF_FIRST = 4'd3;

  typedef enum logic [2:0] {
    MODE_NONE,
    MODE_PIO28,
    MODE_PIO48,
    MODE_DMA28,
    MODE_DMA48
  } mode_t;

  // a decoded request as held by the sequencer
  typedef struct packed {
    mode_t               mode;
    logic                wr;
    logic [STATUS_W-1:0] status;
    logic [7:0]          cmd;
    logic [LBA_W-1:0]    lba;
    logic [COUNT_W-1:0]  count;
    logic [STEP_W-1:0]   last_step;
  } plan_t;

  // one register write
  typedef struct packed {
    logic [TARGET_W-1:0] target;
    logic [OFFSET_W-1:0] reg_offset;
    logic [VALUE_W-1:0]  write_value;
    logic                last;
    logic [STATUS_W-1:0] status;
  } res_t;

endpackage

/* hdl/atatf_if.sv */
// atatf_if: valid/ready channel interfaces for requests, register writes and configuration
// depends on atatf_pkg
interface atatf_req_if import atatf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [LBA_W-1:0]    block_address;
  logic [COUNT_W-1:0]  sector_total;

  modport source (output valid, kind, block_address, sector_total, input ready);
  modport sink   (input valid, kind, block_address, sector_total, output ready);
endinterface

interface atatf_res_if import atatf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [TARGET_W-1:0] target;
  logic [OFFSET_W-1:0] reg_offset;
  logic [VALUE_W-1:0]  write_value;
  logic                last;
  logic [STATUS_W-1:0] status;

  modport source (output valid, target, reg_offset, write_value, last, status, input ready);
  modport sink   (input valid, target, reg_offset, write_value, last, status, output ready);
endinterface

interface atatf_cfg_if;
  logic valid;
  logic ready;
  logic index;
  logic data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/atatf_decode.sv */
// atatf_decode: classifies a request and runs the device, engine and length checks
// depends on atatf_pkg
module atatf_decode import atatf_pkg::*; (
  input  logic [KIND_W-1:0]  kind,
  input  logic [LBA_W-1:0]   block_address,
  input  logic [COUNT_W-1:0] sector_total,
  input  logic               device_present,
  input  logic               dma_available,
  output plan_t              plan
);

  logic [BYTES_W-1:0] bytes;
  logic               too_long;
  logic               wide;

  assign bytes    = {sector_total, {SECTOR_SHIFT{1'b0}}};
  assign too_long = bytes > BYTES_W'(MAX_DMA_BYTES);
  assign wide     = (|block_address[LBA_W-1:LBA28_BITS]) || (sector_total > DMA28_MAX_COUNT);

  always_comb begin
    plan           = '0;
    plan.mode      = MODE_NONE;
    plan.wr        = kind[0];
    plan.lba       = block_address;
    plan.count     = sector_total;
    plan.status    = ST_OK;
    plan.cmd       = 8'h00;
    plan.last_step = LAST_NONE;
    case (kind)
      KIND_PIO28_RD, KIND_PIO28_WR: begin
        if (!device_present) begin
          plan.status = ST_NO_DEV;
        end else begin
          plan.mode      = MODE_PIO28;
          plan.count     = COUNT_W'(1);
          plan.cmd       = kind[0] ? CMD_WRITE_SECTORS : CMD_READ_SECTORS;
          plan.last_step = LAST_PIO28;
        end
      end
      KIND_PIO48_RD, KIND_PIO48_WR: begin
        if (!device_present) begin
          plan.status = ST_NO_DEV;
        end else begin
          plan.mode      = MODE_PIO48;
          plan.cmd       = kind[0] ? CMD_WRITE_SECTORS_EXT : CMD_READ_SECTORS_EXT;
          plan.last_step = LAST_PIO48;
        end
      end
      KIND_DMA_RD, KIND_DMA_WR: begin
        if (!device_present || !dma_available) begin
          plan.status = ST_NO_DEV;
        end else if (sector_total == '0) begin
          plan.status = ST_OK;
        end else if (too_long) begin
          plan.status = ST_TOO_LONG;
        end else if (wide) begin
          plan.mode      = MODE_DMA48;
          plan.cmd       = kind[0] ? CMD_WRITE_DMA_EXT : CMD_READ_DMA_EXT;
          plan.last_step = LAST_DMA48;
        end else begin
          plan.mode      = MODE_DMA28;
          plan.cmd       = kind[0] ? CMD_WRITE_DMA : CMD_READ_DMA;
          plan.last_step = LAST_DMA28;
        end
      end
      default: begin
        plan.status = ST_OK;
      end
    endcase
  end

endmodule

/* hdl/atatf_seq.sv */
// atatf_seq: holds the current request and steps through its register writes, one a cycle while res_ready is high
// depends on atatf_pkg
module atatf_seq import atatf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  plan_valid,
  output logic  plan_ready,
  input  plan_t plan,
  output logic  res_valid,
  input  logic  res_ready,
  output res_t  res
);

  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic [7:0]          value;
  } tf_write_t;

  logic              active;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  plan_t             cur;
  logic              adv;
  logic              at_last;
  logic              take;
  logic [STEP_W-1:0] tf_idx;
  logic [BYTES_W-1:0] bytes;
  logic [7:0]        dir;
  tf_write_t         tf;

  function automatic tf_write_t tf28(input logic [STEP_W-1:0] t, input plan_t r);
    tf_write_t w;
    w = '0;
    case (t)
      4'd0: w = '{OFF_DEVICE, DEV_LBA28 | {4'h0, r.lba[27:24]}};
      4'd1: w = '{OFF_COUNT, r.count[7:0]};
      4'd2: w = '{OFF_LBA_LO, r.lba[7:0]};
      4'd3: w = '{OFF_LBA_MID, r.lba[15:8]};
      4'd4: w = '{OFF_LBA_HI, r.lba[23:16]};
      4'd5: w = '{OFF_COMMAND, r.cmd};
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic tf_write_t tf48(input logic [STEP_W-1:0] t, input plan_t r);
    tf_write_t w;
    w = '0;
    case (t)
      4'd0: w = '{OFF_DEVICE, DEV_LBA48};
      4'd1: w = '{OFF_COUNT, r.count[15:8]};
      4'd2: w = '{OFF_LBA_LO, r.lba[31:24]};
      4'd3: w = '{OFF_LBA_MID, r.lba[39:32]};
      4'd4: w = '{OFF_LBA_HI, r.lba[47:40]};
      4'd5: w = '{OFF_COUNT, r.count[7:0]};
      4'd6: w = '{OFF_LBA_LO, r.lba[7:0]};
      4'd7: w = '{OFF_LBA_MID, r.lba[15:8]};
      4'd8: w = '{OFF_LBA_HI, r.lba[23:16]};
      4'd9: w = '{OFF_COMMAND, r.cmd};
      default: w = '0;
    endcase
    return w;
  endfunction

  assign at_last    = (step == cur.last_step);
  assign adv        = active && res_ready;
  assign plan_ready = !active || (adv && at_last);
  assign take       = plan_valid && plan_ready;
  assign res_valid  = active;
  assign step_next  = step + STEP_W'(1);
  assign tf_idx     = step - DMA_TF_FIRST;
  assign bytes      = {cur.count, {SECTOR_SHIFT{1'b0}}};
  assign dir        = cur.wr ? BM_STOP : BM_DIR_READ;

  // current write
  always_comb begin
    res = '0;
    tf  = '0;
    case (cur.mode)
      MODE_PIO28: begin
        tf = tf28(step, cur);
        res.target      = TGT_TASKFILE;
        res.reg_offset  = tf.offset;
        res.write_value = {8'h00, tf.value};
      end
      MODE_PIO48: begin
        tf = tf48(step, cur);
        res.target      = TGT_TASKFILE;
        res.reg_offset  = tf.offset;
        res.write_value = {8'h00, tf.value};
      end
      MODE_DMA28, MODE_DMA48: begin
        tf = (cur.mode == MODE_DMA48) ? tf48(tf_idx, cur) : tf28(tf_idx, cur);
        if (step == 4'd0) begin
          res.target      = TGT_PRD;
          res.write_value = bytes[VALUE_W-1:0];
        end else if (step == 4'd1) begin
          res.target      = TGT_BMCMD;
          res.write_value = {8'h00, BM_STOP};
        end else if (step == 4'd2) begin
          res.target      = TGT_BMCMD;
          res.write_value = {8'h00, dir};
        end else if (at_last) begin
          res.target      = TGT_BMCMD;
          res.write_value = {8'h00, dir | BM_START};
        end else begin
          res.target      = TGT_TASKFILE;
          res.reg_offset  = tf.offset;
          res.write_value = {8'h00, tf.value};
        end
      end
      default: begin
        res.target = TGT_NONE;
      end
    endcase
    res.last   = at_last;
    res.status = at_last ? cur.status : ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      step   <= '0;
    end else if (take) begin
      active <= 1'b1;
      step   <= '0;
    end else if (adv) begin
      if (at_last) begin
        active <= 1'b0;
      end else begin
        step <= step_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= plan;
    end
  end

endmodule

/* hdl/atatf_outreg.sv */
// atatf_outreg: result register between the sequencer and the write channel
// depends on atatf_pkg and atatf_res_if
module atatf_outreg import atatf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  res_t               in_data,
  atatf_res_if.source        res
);

  logic valid;
  res_t data;

  assign in_ready        = !valid || res.ready;
  assign res.valid       = valid;
  assign res.target      = data.target;
  assign res.reg_offset  = data.reg_offset;
  assign res.write_value = data.write_value;
  assign res.last        = data.last;
  assign res.status      = data.status;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= in_data;
    end
  end

endmodule

/* hdl/ata_taskfile_command_issue.sv */
// ata_taskfile_command_issue: top level of the taskfile command issue block
// depends on atatf_pkg, atatf_if, atatf_decode, atatf_seq and atatf_outreg
//
// usage
// - cfg: register writes, index 0 device present, index 1 dma engine available;
//   always ready, both registers clear to 0 at reset; write only while idle
// - req: one transfer request per item (kind, block address, sector count)
// - res: the register writes that start the transfer, one item per write, in
//   order; the final item of a request has last set and carries its status
// - a request gives 1, 6, 10 or 14 writes: one for a refused or ignored
//   request, 6 for pio 28-bit, 10 for pio 48-bit or dma 28-bit, 14 for dma 48-bit
// - the request is registered in the sequencer, and its first write then in the
//   result register before it appears on res
// - throughput: one write per cycle while res.ready is high; the next request is
//   taken in the cycle its predecessor's final write moves into the result
//   register
// - stall: a held res.ready freezes the result register and then the sequencer;
//   req.ready drops until the sequencer can move on; nothing is lost
// - reset (rst, synchronous): sequencer and result register go empty, no
//   clearing pass
module ata_taskfile_command_issue import atatf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  atatf_cfg_if.sink   cfg,
  atatf_req_if.sink   req,
  atatf_res_if.source res
);

  logic  device_present;
  logic  dma_available;
  plan_t plan;
  logic  seq_valid;
  logic  seq_ready;
  res_t  seq_res;

  // configuration registers, taken at once
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_present <= 1'b0;
      dma_available  <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_DEVICE_PRESENT: device_present <= cfg.data;
        CFG_DMA_AVAILABLE:  dma_available  <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // request checks and classification, straight off the request channel
  atatf_decode u_decode (
    .kind           (req.kind),
    .block_address  (req.block_address),
    .sector_total   (req.sector_total),
    .device_present (device_present),
    .dma_available  (dma_available),
    .plan           (plan)
  );

  // write sequencer: one request register and a step count
  atatf_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .plan_valid (req.valid),
    .plan_ready (req.ready),
    .plan       (plan),
    .res_valid  (seq_valid),
    .res_ready  (seq_ready),
    .res        (seq_res)
  );

  // result register onto the write channel
  atatf_outreg u_outreg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (seq_valid),
    .in_ready (seq_ready),
    .in_data  (seq_res),
    .res      (res)
  );

endmodule

/* hdl/atatf_checker.sv */
// atatf_checker: port-level checks on the register write channel, bound to the top level
// depends on atatf_pkg and ata_taskfile_command_issue
module atatf_checker import atatf_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                res_valid,
  input logic                res_ready,
  input logic [TARGET_W-1:0] res_target,
  input logic [OFFSET_W-1:0] res_reg_offset,
  input logic [VALUE_W-1:0]  res_write_value,
  input logic                res_last,
  input logic [STATUS_W-1:0] res_status
);

  // a stalled write holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_target) &&
      $stable(res_write_value) && $stable(res_last) && $stable(res_status))
    else $error("stalled write changed");

  // status only on the final write
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_last |-> res_status == ST_OK)
    else $error("status on a non-final write");

  // a no-write item always ends its request
  a_none_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_target == TGT_NONE |-> res_last)
    else $error("no-write item not final");

  // offsets only for taskfile writes
  a_offset: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_target != TGT_TASKFILE |-> res_reg_offset == OFF_NONE)
    else $error("offset on a non-taskfile write");

  // channel empty after reset
  a_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("write presented after reset");

endmodule

bind ata_taskfile_command_issue atatf_checker u_atatf_checker (
  .clk             (clk),
  .rst             (rst),
  .res_valid       (res.valid),
  .res_ready       (res.ready),
  .res_target      (res.target),
  .res_reg_offset  (res.reg_offset),
  .res_write_value (res.write_value),
  .res_last        (res.last),
  .res_status      (res.status)
);
